>>> design/mrpt_pkg.sv
// mrpt_pkg: shared types and constants of the miller-rabin test block
// used by mrpt_modmul and miller_rabin_primality_test; no dependencies
package mrpt_pkg;

  // width of the candidate and of every random field
  localparam int CAND_W = 31;
  // number of test rounds and of random fields carried by one input word
  localparam int ROUNDS = 5;
  localparam int RAND_FIELDS = 5;
  localparam int ROUND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int FIDX_W = (RAND_FIELDS > 1) ? $clog2(RAND_FIELDS) : 1;
  // counter wide enough to index every bit of a candidate
  localparam int CNT_W = $clog2(CAND_W);

  typedef logic [CAND_W-1:0] word_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STRIP,
    ST_BASE,
    ST_BASE_WAIT,
    ST_SQ,
    ST_SQ_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_TEST,
    ST_CHAIN,
    ST_CHAIN_WAIT,
    ST_DONE
  } st_t;

  // request to the modular multiplier: x * y mod m, needs y < m
  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
    word_t m;
  } mm_req_t;

  // response: done pulses for one cycle while prod holds the result
  typedef struct packed {
    logic  done;
    word_t prod;
  } mm_rsp_t;

endpackage

>>> design/mrpt_modmul.sv
// mrpt_modmul: bit-serial interleaved modular multiplier, one bit of x a cycle
// depends on mrpt_pkg
module mrpt_modmul import mrpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  word_t            x_r, x_nxt;
  word_t            y_r, y_nxt;
  word_t            m_r, m_nxt;
  word_t            acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [CAND_W+1:0] sum;
  logic [CAND_W+1:0] m1;
  logic [CAND_W+1:0] m2;
  logic [CAND_W+1:0] red;

  // one step: acc = 2*acc + bit*y, then bring below m (sum stays under 3m)
  always_comb begin
    m1  = {2'b00, m_r};
    m2  = {1'b0, m_r, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + {2'b00, (x_r[CAND_W-1] ? y_r : '0)};
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  // next values
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      x_nxt    = req.x;
      y_nxt    = req.y;
      m_nxt    = req.m;
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(CAND_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = red[CAND_W-1:0];
      x_nxt   = {x_r[CAND_W-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

  // a new request only lands on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r && !done_r)
    else $error("modmul started while busy");

  // accumulator stays reduced through the whole run
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r || done_r) |-> (acc_r < m_r))
    else $error("modmul accumulator not reduced");

  // the addend must already be reduced for the two-compare reduction to hold
  a_y_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (y_r < m_r))
    else $error("modmul addend not below modulus");

  // done follows the last step of a run
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("modmul done without a run");

endmodule

>>> design/miller_rabin_primality_test.sv
// miller_rabin_primality_test: probable-prime test of one 31-bit candidate
// depends on mrpt_pkg and mrpt_modmul
//
// Input channel: in_valid / in_stall carry one word, the candidate plus five
// random values, one per round (rounds past the fifth reuse them cyclically).
// Output channel: out_valid / out_stall carry one word per input word,
// out_is_prime, 1 for probably prime, 0 for composite or below two.
// Candidates of 3 or less and even ones are settled in the check state: the
// result goes through the done state to the output register, then back to idle.
// Odd candidates of 5 or more: factors of two are stripped from n-1, then
// per round one reduction of the random value and a square-and-multiply
// over all 31 exponent bits, each modular product done on the single
// bit-serial multiplier; a round costs 33 to 62 products including the
// squaring chain, and a word ends early when a round fails.
// The multiplier works one operand bit a cycle and sets the pace of a test.
// in_stall is high from acceptance until the result is handed to the output
// register; the output register lets the next word be taken while a result
// still waits behind out_stall, and a stalled result holds.
// Synchronous active-low reset clears the sequencer and the output register.
module miller_rabin_primality_test import mrpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CAND_W-1:0] in_candidate,
  input  logic [CAND_W-1:0] in_random_round_0,
  input  logic [CAND_W-1:0] in_random_round_1,
  input  logic [CAND_W-1:0] in_random_round_2,
  input  logic [CAND_W-1:0] in_random_round_3,
  input  logic [CAND_W-1:0] in_random_round_4,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_is_prime
);

  localparam int RAND_FIDX_LAST = RAND_FIELDS - 1;

  st_t state_r, state_nxt;

  word_t              n_r, n_nxt;
  word_t              rnd_r [RAND_FIELDS];
  word_t              d_r, d_nxt;
  word_t              e_r, e_nxt;
  word_t              a_r, a_nxt;
  word_t              x_r, x_nxt;
  logic [CNT_W-1:0]   s_r, s_nxt;
  logic [CNT_W-1:0]   ecnt_r, ecnt_nxt;
  logic [CNT_W-1:0]   sq_cnt_r, sq_cnt_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [FIDX_W-1:0]  fidx_r, fidx_nxt;
  logic               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_is_prime_r, out_is_prime_nxt;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic  in_take;
  logic  out_take;
  logic  out_free;
  logic  round_last;
  logic  small_n;
  logic  small_prime;
  word_t n_minus1;
  logic  x_pass;
  logic  chain_hit;
  logic  chain_end;

  mrpt_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // handshakes and shared decodes
  assign in_take     = in_valid && !in_stall;
  assign out_take    = out_valid_r && !out_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign round_last  = (round_r == ROUND_W'(ROUNDS - 1));
  assign small_n     = (n_r <= word_t'(1));
  assign small_prime = (n_r == word_t'(2)) || (n_r == word_t'(3));
  assign n_minus1    = n_r - word_t'(1);
  assign x_pass      = (x_r == word_t'(1)) || (x_r == n_minus1);
  assign chain_hit   = (mm_rsp.prod == n_minus1);
  assign chain_end   = ((sq_cnt_r + 1'b1) == s_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (small_n || small_prime || !n_r[0]) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (d_r[0]) state_nxt = ST_BASE;
      end
      ST_BASE: state_nxt = ST_BASE_WAIT;
      ST_BASE_WAIT: begin
        if (mm_rsp.done) state_nxt = ST_SQ;
      end
      ST_SQ: state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (mm_rsp.done) begin
          if (e_r[CAND_W-1]) begin
            state_nxt = ST_MUL;
          end else if (ecnt_r == '0) begin
            state_nxt = ST_TEST;
          end else begin
            state_nxt = ST_SQ;
          end
        end
      end
      ST_MUL: state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mm_rsp.done) begin
          if (ecnt_r == '0) begin
            state_nxt = ST_TEST;
          end else begin
            state_nxt = ST_SQ;
          end
        end
      end
      ST_TEST: begin
        if (x_pass) begin
          state_nxt = round_last ? ST_DONE : ST_BASE;
        end else if (s_r > CNT_W'(1)) begin
          state_nxt = ST_CHAIN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CHAIN: state_nxt = ST_CHAIN_WAIT;
      ST_CHAIN_WAIT: begin
        if (mm_rsp.done) begin
          if (chain_hit) begin
            state_nxt = round_last ? ST_DONE : ST_BASE;
          end else if (chain_end) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHAIN;
          end
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates and multiplier requests
  always_comb begin
    n_nxt            = n_r;
    d_nxt            = d_r;
    e_nxt            = e_r;
    a_nxt            = a_r;
    x_nxt            = x_r;
    s_nxt            = s_r;
    ecnt_nxt         = ecnt_r;
    sq_cnt_nxt       = sq_cnt_r;
    round_nxt        = round_r;
    fidx_nxt         = fidx_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_take ? 1'b0 : out_valid_r;
    out_is_prime_nxt = out_is_prime_r;
    mm_req.start     = 1'b0;
    mm_req.x         = x_r;
    mm_req.y         = x_r;
    mm_req.m         = n_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) n_nxt = in_candidate;
      end
      // trivial candidates settle here
      ST_CHECK: begin
        res_nxt   = small_prime;
        d_nxt     = n_minus1;
        s_nxt     = '0;
        round_nxt = '0;
        fidx_nxt  = '0;
      end
      // n-1 = 2^s * d
      ST_STRIP: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end
      end
      // base: random mod (n-3), taken as random * 1 mod (n-3)
      ST_BASE: begin
        mm_req.start = 1'b1;
        mm_req.x     = rnd_r[fidx_r];
        mm_req.y     = word_t'(1);
        mm_req.m     = n_r - word_t'(3);
      end
      ST_BASE_WAIT: begin
        if (mm_rsp.done) begin
          a_nxt    = mm_rsp.prod + word_t'(2);
          x_nxt    = word_t'(1);
          e_nxt    = d_r;
          ecnt_nxt = CNT_W'(CAND_W - 1);
        end
      end
      // left-to-right square-and-multiply over the exponent bits
      ST_SQ: begin
        mm_req.start = 1'b1;
      end
      ST_SQ_WAIT: begin
        if (mm_rsp.done) begin
          x_nxt = mm_rsp.prod;
          if (!e_r[CAND_W-1]) begin
            e_nxt    = e_r << 1;
            ecnt_nxt = ecnt_r - 1'b1;
          end
        end
      end
      ST_MUL: begin
        mm_req.start = 1'b1;
        mm_req.y     = a_r;
      end
      ST_MUL_WAIT: begin
        if (mm_rsp.done) begin
          x_nxt    = mm_rsp.prod;
          e_nxt    = e_r << 1;
          ecnt_nxt = ecnt_r - 1'b1;
        end
      end
      // round verdict on a^d
      ST_TEST: begin
        sq_cnt_nxt = CNT_W'(1);
        if (x_pass) begin
          res_nxt   = 1'b1;
          round_nxt = round_r + 1'b1;
          fidx_nxt  = (fidx_r == FIDX_W'(RAND_FIDX_LAST)) ? '0 : fidx_r + 1'b1;
        end else begin
          res_nxt = 1'b0;
        end
      end
      // further squarings looking for n-1
      ST_CHAIN: begin
        mm_req.start = 1'b1;
      end
      ST_CHAIN_WAIT: begin
        if (mm_rsp.done) begin
          x_nxt      = mm_rsp.prod;
          sq_cnt_nxt = sq_cnt_r + 1'b1;
          if (chain_hit) begin
            res_nxt   = 1'b1;
            round_nxt = round_r + 1'b1;
            fidx_nxt  = (fidx_r == FIDX_W'(RAND_FIDX_LAST)) ? '0 : fidx_r + 1'b1;
          end else begin
            res_nxt = 1'b0;
          end
        end
      end
      // hand the verdict to the output register
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    d_r            <= d_nxt;
    e_r            <= e_nxt;
    a_r            <= a_nxt;
    x_r            <= x_nxt;
    s_r            <= s_nxt;
    ecnt_r         <= ecnt_nxt;
    sq_cnt_r       <= sq_cnt_nxt;
    round_r        <= round_nxt;
    fidx_r         <= fidx_nxt;
    res_r          <= res_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  // random values of the accepted word
  always_ff @(posedge clk) begin
    if (in_take) begin
      rnd_r[0] <= in_random_round_0;
      rnd_r[1] <= in_random_round_1;
      rnd_r[2] <= in_random_round_2;
      rnd_r[3] <= in_random_round_3;
      rnd_r[4] <= in_random_round_4;
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // the base lies in [2, n-2]
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> (a_r >= word_t'(2)) && (a_r < n_r - word_t'(1)))
    else $error("base out of range");

  // the power stays reduced modulo n
  a_x_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST) |-> (x_r < n_r))
    else $error("power not reduced");

  // n-1 of an odd candidate has at least one factor of two, d is odd
  a_s_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST) |-> (s_r != '0) && d_r[0])
    else $error("bad split of n-1");

  // a result only appears out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result without a finished test");

endmodule

>>> sim/tb.sv
// tb: self-checking bench for the miller-rabin primality test block
// depends on mrpt_pkg and miller_rabin_primality_test; holds its own verdict predictor
`timescale 1ns / 1ps

module tb import mrpt_pkg::*; ();

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 1080;
  localparam int MAX_IDLE = 11;
  localparam int SETTLE_CYCLES = 40;
  // slowest run: every word through all rounds plus both idles, with a wide margin
  localparam longint CYCLE_LIMIT = 64'd60_000_000;
  localparam int RND_W = RAND_FIELDS * CAND_W;
  localparam word_t ALL_ONES = {CAND_W{1'b1}};

  typedef logic [RND_W-1:0] rnd_pool_t;

  // how the five random fields of a word are filled
  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_RAND,
    FILL_MIX
  } fill_t;

  typedef struct packed {
    logic      drain;
    logic [3:0] gap;
    word_t     cand;
    rnd_pool_t rnd;
  } test_word_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t in_candidate = '0;
  word_t in_random_round_0 = '0;
  word_t in_random_round_1 = '0;
  word_t in_random_round_2 = '0;
  word_t in_random_round_3 = '0;
  word_t in_random_round_4 = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  out_is_prime;

  test_word_t cand_q[$];
  logic       verdict_q[$];
  test_word_t next_word;
  bit         have_next = 1'b0;
  int         gap_left = 0;
  bit         took_word = 1'b0;
  int         stall_left = 0;
  int         n_results = 0;
  int         errors = 0;
  longint     cycles = 0;

  miller_rabin_primality_test dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_candidate     (in_candidate),
    .in_random_round_0(in_random_round_0),
    .in_random_round_1(in_random_round_1),
    .in_random_round_2(in_random_round_2),
    .in_random_round_3(in_random_round_3),
    .in_random_round_4(in_random_round_4),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_prime     (out_is_prime)
  );

  always #HALF_PERIOD clk = ~clk;

  // b^e mod m, every product stays below 2^62
  function automatic longint unsigned pow_mod(input longint unsigned b,
                                              input longint unsigned e,
                                              input longint unsigned m);
    longint unsigned acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  // expected verdict: 1 when n survives every round
  function automatic logic probable_prime(input word_t n, input rnd_pool_t rnd);
    longint unsigned nn, d, a, x, r;
    int s;
    logic pass;
    nn = n;
    if (nn <= 1) return 1'b0;
    if (nn == 2 || nn == 3) return 1'b1;
    if (!nn[0]) return 1'b0;
    d = nn - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int k = 0; k < ROUNDS; k++) begin
      r = rnd[(k % RAND_FIELDS) * CAND_W +: CAND_W];
      a = 2 + r % (nn - 3);
      x = pow_mod(a, d, nn);
      pass = (x == 1) || (x == nn - 1);
      for (int j = 1; j < s && !pass; j++) begin
        x = (x * x) % nn;
        if (x == nn - 1) pass = 1'b1;
      end
      if (!pass) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic rnd_pool_t fill_rnd(input fill_t how);
    rnd_pool_t pool;
    int pick;
    for (int k = 0; k < RAND_FIELDS; k++) begin
      pick = $urandom_range(0, 9);
      case (how)
        FILL_ZERO: pool[k*CAND_W +: CAND_W] = '0;
        FILL_ONES: pool[k*CAND_W +: CAND_W] = ALL_ONES;
        FILL_RAND: pool[k*CAND_W +: CAND_W] = word_t'($urandom);
        default: begin
          if (pick == 0) pool[k*CAND_W +: CAND_W] = '0;
          else if (pick == 1) pool[k*CAND_W +: CAND_W] = ALL_ONES;
          else pool[k*CAND_W +: CAND_W] = word_t'($urandom);
        end
      endcase
    end
    return pool;
  endfunction

  // gaps: random, but every fourth stretch of fifty words runs back to back
  task automatic queue_word(input word_t c, input rnd_pool_t rnd, input logic drain);
    test_word_t w;
    w.cand = c;
    w.rnd = rnd;
    w.drain = drain;
    w.gap = ((cand_q.size() / 50) % 4 == 3) ? 4'd0 : 4'($urandom_range(0, MAX_IDLE));
    cand_q.push_back(w);
  endtask

  // input side: predict each accepted word
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      verdict_q.push_back(probable_prime(in_candidate,
        {in_random_round_4, in_random_round_3, in_random_round_2,
         in_random_round_1, in_random_round_0}));
      took_word = 1'b1;
    end
  end

  // driver: hold a stalled word, otherwise fetch the next one after its gap
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took_word)) begin
      took_word = 1'b0;
      if (!have_next && cand_q.size() != 0 &&
          (!cand_q[0].drain || verdict_q.size() == 0)) begin
        next_word = cand_q.pop_front();
        have_next = 1'b1;
        gap_left = next_word.gap;
      end
      if (have_next && gap_left == 0) begin
        in_valid <= 1'b1;
        in_candidate <= next_word.cand;
        in_random_round_0 <= next_word.rnd[0*CAND_W +: CAND_W];
        in_random_round_1 <= next_word.rnd[1*CAND_W +: CAND_W];
        in_random_round_2 <= next_word.rnd[2*CAND_W +: CAND_W];
        in_random_round_3 <= next_word.rnd[3*CAND_W +: CAND_W];
        in_random_round_4 <= next_word.rnd[4*CAND_W +: CAND_W];
        have_next = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (have_next) gap_left--;
      end
    end
  end

  // monitor: compare each result word with the oldest verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result word, is_prime actual %0b", out_is_prime);
        errors++;
      end else begin
        logic want;
        want = verdict_q.pop_front();
        if (out_is_prime !== want) begin
          $error("is_prime mismatch: expected %0b actual %0b", want, out_is_prime);
          errors++;
        end
      end
      n_results++;
      stall_left = ((n_results / 40) % 4 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
    end
  end

  // result stall counts down only while a result is offered
  always @(negedge clk) begin
    out_stall <= (stall_left > 0);
    if (out_valid && stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int kind, s;
    longint unsigned p, q, d, dmax;
    word_t c;

    // directed: trivial answers, tiny and extreme candidates, pseudoprimes
    queue_word(31'd0, fill_rnd(FILL_RAND), 1'b0);
    queue_word(31'd1, fill_rnd(FILL_ONES), 1'b0);
    queue_word(31'd2, fill_rnd(FILL_ZERO), 1'b0);
    queue_word(31'd3, fill_rnd(FILL_RAND), 1'b0);
    queue_word(31'd4, fill_rnd(FILL_ONES), 1'b0);
    queue_word(31'd5, fill_rnd(FILL_ZERO), 1'b0);
    queue_word(31'd5, fill_rnd(FILL_ONES), 1'b0);
    queue_word(31'd7, fill_rnd(FILL_RAND), 1'b0);
    queue_word(31'd9, fill_rnd(FILL_ZERO), 1'b0);
    queue_word(31'd561, fill_rnd(FILL_RAND), 1'b0);
    queue_word(31'd1105, fill_rnd(FILL_ONES), 1'b0);
    // strong pseudoprimes to base two, most with all rounds forced onto base two
    queue_word(31'd2047, fill_rnd(FILL_ZERO), 1'b0);
    queue_word(31'd2047, fill_rnd(FILL_RAND), 1'b0);
    queue_word(31'd1373653, fill_rnd(FILL_ZERO), 1'b0);
    queue_word(31'd25326001, fill_rnd(FILL_ZERO), 1'b0);
    // long squaring chains
    queue_word(31'd65537, fill_rnd(FILL_RAND), 1'b1);
    queue_word(31'd2013265921, fill_rnd(FILL_MIX), 1'b0);
    queue_word(31'd1073741825, fill_rnd(FILL_RAND), 1'b0);
    // top of the candidate range
    queue_word(ALL_ONES, fill_rnd(FILL_ONES), 1'b0);
    queue_word(ALL_ONES, fill_rnd(FILL_ZERO), 1'b0);
    queue_word(ALL_ONES - 31'd1, fill_rnd(FILL_RAND), 1'b0);
    queue_word(ALL_ONES - 31'd2, fill_rnd(FILL_MIX), 1'b0);
    queue_word(ALL_ONES - 31'd4, fill_rnd(FILL_RAND), 1'b0);

    // random: mostly odd candidates that reach the round loop
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        c = word_t'($urandom_range(0, 20));
      end else if (kind < 40) begin
        c = word_t'($urandom) & (ALL_ONES - 31'd1);
      end else if (kind < 55) begin
        c = word_t'($urandom_range(2, 32767) * 2 + 1);
      end else if (kind < 70) begin
        c = word_t'($urandom) | 31'd1;
        if (c < 5) c = 31'd5;
      end else if (kind < 85) begin
        // product of two odd factors below the square root of the range
        p = $urandom_range(1, 23169) * 2 + 1;
        q = $urandom_range(1, 23169) * 2 + 1;
        c = word_t'(p * q);
      end else begin
        // n-1 with many factors of two
        s = $urandom_range(10, 30);
        dmax = (64'h7FFF_FFFE) >> s;
        d = $urandom_range(1, int'(dmax)) | 1;
        if (d > dmax) d = d - 2;
        c = word_t'((d << s) + 1);
      end
      queue_word(c, fill_rnd(FILL_MIX), (i % 150 == 75));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cand_q.size() != 0 || have_next || in_valid) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
